// ----- sv/dlc_pkg.sv -----
// Shared types and codes for the password door lock controller.
// Used by dlc_core and password_door_lock_controller; no dependencies.
package dlc_pkg;

  // Event kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_PASS = 2'd0,
    REQ_KEY  = 2'd1,
    REQ_TICK = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    MODE_NEW        = 3'd0,
    MODE_CONFIRM    = 3'd1,
    MODE_MENU       = 3'd2,
    MODE_CHK_CHANGE = 3'd3,
    MODE_CHK_OPEN   = 3'd4,
    MODE_LOCKOUT    = 3'd5,
    MODE_LOCKING    = 3'd6,
    MODE_UNLOCKING  = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    RES_NONE         = 4'd0,
    RES_SET_OK       = 4'd1,
    RES_SET_BAD      = 4'd2,
    RES_CONFIRM      = 4'd3,
    RES_PASS_OK      = 4'd4,
    RES_WRONG        = 4'd5,
    RES_LOCKOUT      = 4'd6,
    RES_LOCKOUT_OVER = 4'd7,
    RES_UNLOCKING    = 4'd8,
    RES_DONE         = 4'd9,
    RES_IGNORED      = 4'd10
  } res_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LOCKOUT_TICKS = 2'd0,
    CFG_MOTOR_TICKS   = 2'd1,
    CFG_MAX_ATTEMPTS  = 2'd2
  } cfg_e;

  localparam logic [7:0] KEY_CHANGE = 8'd42;  // '*'
  localparam logic [7:0] KEY_OPEN   = 8'd37;  // '%'

  localparam logic [7:0] LOCKOUT_TICKS_RST = 8'd240;
  localparam logic [7:0] MOTOR_TICKS_RST   = 8'd60;
  localparam logic [2:0] MAX_ATTEMPTS_RST  = 3'd3;

  typedef struct packed {
    logic [7:0] lockout_ticks;
    logic [7:0] motor_phase_ticks;
    logic [2:0] max_attempts;
  } cfg_t;

  typedef struct packed {
    res_e       result_code;
    mode_e      mode;
    logic [2:0] attempts;
    logic       buzzer_on;
    logic       motor_lock;
    logic       motor_unlock;
  } out_t;

endpackage

// ----- sv/dlc_core.sv -----
// Lock controller state machine: mode, stored and first password, counters.
// Depends on dlc_pkg. Processes one event per cycle when en_i is high.
module dlc_core #(
  parameter int PASS_BYTES = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  dlc_pkg::req_e             req_i,
  input  logic [8*PASS_BYTES-1:0]   pass_i,
  input  logic [7:0]                key_i,
  input  dlc_pkg::cfg_t             cfg_i,
  output dlc_pkg::out_t             res_o
);

  localparam int PW = 8 * PASS_BYTES;

  dlc_pkg::mode_e  mode_q, mode_d;
  logic [PW-1:0]   stored_q, stored_d;
  logic [PW-1:0]   first_q, first_d;
  logic [2:0]      wrong_q, wrong_d;
  logic [7:0]      tick_q, tick_d;
  logic            buzz_q, buzz_d;
  dlc_pkg::res_e   res;

  logic [2:0] wrong_inc;
  logic [7:0] tick_inc;

  assign wrong_inc = wrong_q + 3'd1;
  assign tick_inc  = tick_q + 8'd1;

  // Next state.
  always_comb begin
    mode_d   = mode_q;
    stored_d = stored_q;
    first_d  = first_q;
    wrong_d  = wrong_q;
    tick_d   = tick_q;
    buzz_d   = buzz_q;
    res      = dlc_pkg::RES_NONE;
    if (en_i) begin
      case (req_i)
        dlc_pkg::REQ_PASS: begin
          case (mode_q)
            dlc_pkg::MODE_NEW: begin
              first_d = pass_i;
              mode_d  = dlc_pkg::MODE_CONFIRM;
              res     = dlc_pkg::RES_CONFIRM;
            end
            dlc_pkg::MODE_CONFIRM: begin
              if (pass_i == first_q) begin
                stored_d = pass_i;
                mode_d   = dlc_pkg::MODE_MENU;
                res      = dlc_pkg::RES_SET_OK;
              end else begin
                mode_d = dlc_pkg::MODE_NEW;
                res    = dlc_pkg::RES_SET_BAD;
              end
            end
            dlc_pkg::MODE_CHK_CHANGE, dlc_pkg::MODE_CHK_OPEN: begin
              if (pass_i == stored_q) begin
                wrong_d = '0;
                res     = dlc_pkg::RES_PASS_OK;
                if (mode_q == dlc_pkg::MODE_CHK_CHANGE) begin
                  mode_d = dlc_pkg::MODE_NEW;
                end else begin
                  tick_d = '0;
                  mode_d = dlc_pkg::MODE_LOCKING;
                end
              end else if (wrong_inc == cfg_i.max_attempts) begin
                wrong_d = '0;
                buzz_d  = 1'b1;
                tick_d  = '0;
                mode_d  = dlc_pkg::MODE_LOCKOUT;
                res     = dlc_pkg::RES_LOCKOUT;
              end else begin
                wrong_d = wrong_inc;
                res     = dlc_pkg::RES_WRONG;
              end
            end
            default: res = dlc_pkg::RES_IGNORED;
          endcase
        end
        dlc_pkg::REQ_KEY: begin
          if (mode_q != dlc_pkg::MODE_MENU) begin
            res = dlc_pkg::RES_IGNORED;
          end else if (key_i == dlc_pkg::KEY_CHANGE) begin
            wrong_d = '0;
            mode_d  = dlc_pkg::MODE_CHK_CHANGE;
          end else if (key_i == dlc_pkg::KEY_OPEN) begin
            wrong_d = '0;
            mode_d  = dlc_pkg::MODE_CHK_OPEN;
          end else begin
            res = dlc_pkg::RES_IGNORED;
          end
        end
        dlc_pkg::REQ_TICK: begin
          // The counter runs in every mode; timed modes compare after the increment.
          tick_d = tick_inc;
          case (mode_q)
            dlc_pkg::MODE_LOCKOUT: begin
              if (tick_inc == cfg_i.lockout_ticks) begin
                tick_d = '0;
                buzz_d = 1'b0;
                mode_d = dlc_pkg::MODE_MENU;
                res    = dlc_pkg::RES_LOCKOUT_OVER;
              end
            end
            dlc_pkg::MODE_LOCKING: begin
              if (tick_inc == cfg_i.motor_phase_ticks) begin
                tick_d = '0;
                mode_d = dlc_pkg::MODE_UNLOCKING;
                res    = dlc_pkg::RES_UNLOCKING;
              end
            end
            dlc_pkg::MODE_UNLOCKING: begin
              if (tick_inc == cfg_i.motor_phase_ticks) begin
                tick_d = '0;
                mode_d = dlc_pkg::MODE_MENU;
                res    = dlc_pkg::RES_DONE;
              end
            end
            default: res = dlc_pkg::RES_NONE;
          endcase
        end
        default: res = dlc_pkg::RES_IGNORED;
      endcase
    end
  end

  // Result fields reflect the state after the event.
  always_comb begin
    res_o.result_code  = res;
    res_o.mode         = mode_d;
    res_o.attempts     = wrong_d;
    res_o.buzzer_on    = buzz_d;
    res_o.motor_lock   = (mode_d == dlc_pkg::MODE_LOCKING);
    res_o.motor_unlock = (mode_d == dlc_pkg::MODE_UNLOCKING);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= dlc_pkg::MODE_NEW;
      stored_q <= '0;
      first_q  <= '0;
      wrong_q  <= '0;
      tick_q   <= '0;
      buzz_q   <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      stored_q <= stored_d;
      first_q  <= first_d;
      wrong_q  <= wrong_d;
      tick_q   <= tick_d;
      buzz_q   <= buzz_d;
    end
  end

endmodule

// ----- sv/password_door_lock_controller.sv -----
// Password door lock controller: stream ports, configuration registers and
// the input and result register stages around dlc_core. Depends on dlc_pkg.
// Path: an accepted transaction waits in the input register, moves into the result
// register when the core advances, and is held on m_axis there until taken.
// Throughput: one transaction per cycle unless m_axis stalls; the input register
// drains into the result register whenever that register is empty or being taken.
// Reset: asynchronous active low; clears the stages, the state and the
// configuration registers to 240, 60 and 3.
module password_door_lock_controller #(
  parameter int PASS_BYTES = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: pass_value [8*PASS_BYTES-1:0], key_code above it
  input  logic [8*PASS_BYTES+7:0]   s_axis_tdata,
  // tuser: req_type
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: result_code[3:0], mode[6:4], attempts[9:7], buzzer_on[10],
  // motor_lock[11], motor_unlock[12], zero fill [15:13]
  output logic [15:0]               m_axis_tdata,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_addr_i,
  input  logic [7:0]                cfg_wdata_i
);

  localparam int PW = 8 * PASS_BYTES;

  dlc_pkg::cfg_t cfg_q;

  logic              in_valid_q;
  dlc_pkg::req_e     in_req_q;
  logic [PW-1:0]     in_pass_q;
  logic [7:0]        in_key_q;
  logic              advance;

  logic              out_valid_q;
  dlc_pkg::out_t     out_q;
  dlc_pkg::out_t     core_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_ticks     <= dlc_pkg::LOCKOUT_TICKS_RST;
      cfg_q.motor_phase_ticks <= dlc_pkg::MOTOR_TICKS_RST;
      cfg_q.max_attempts      <= dlc_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_we_i) begin
      case (dlc_pkg::cfg_e'(cfg_addr_i))
        dlc_pkg::CFG_LOCKOUT_TICKS: cfg_q.lockout_ticks     <= cfg_wdata_i;
        dlc_pkg::CFG_MOTOR_TICKS:   cfg_q.motor_phase_ticks <= cfg_wdata_i;
        dlc_pkg::CFG_MAX_ATTEMPTS:  cfg_q.max_attempts      <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q  <= dlc_pkg::req_e'(s_axis_tuser);
      in_pass_q <= s_axis_tdata[PW-1:0];
      in_key_q  <= s_axis_tdata[PW+7:PW];
    end
  end

  dlc_core #(
    .PASS_BYTES(PASS_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_req_q),
    .pass_i (in_pass_q),
    .key_i  (in_key_q),
    .cfg_i  (cfg_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.motor_unlock, out_q.motor_lock, out_q.buzzer_on,
                          out_q.attempts, out_q.mode, out_q.result_code};

  // A stalled input stage always holds a pending item.
  a_ready_low_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input stalled without a pending item");

  // Every item that leaves the input stage lands in the result register.
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item did not reach the result register");

  // A lockout result always comes with the buzzer on and the count cleared.
  a_lockout_buzz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.result_code == dlc_pkg::RES_LOCKOUT)
      |-> out_q.buzzer_on && (out_q.attempts == 3'd0)
        && (out_q.mode == dlc_pkg::MODE_LOCKOUT))
    else $error("lockout result without buzzer");

  // The motor is never driven both ways at once.
  a_motor_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.motor_lock && out_q.motor_unlock))
    else $error("motor driven in both directions");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for password_door_lock_controller: directed table then random
// event sequences, each result checked against its table row or an in-bench lock model.
// Depends on dlc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 6;
  localparam int NUM_PHASES     = 6;
  // Event kind that the block must answer with an ignore code.
  localparam logic [1:0] REQ_UNDEFINED = 2'd3;

  typedef struct {
    bit            is_cfg;
    dlc_pkg::cfg_e reg_idx;
    logic [7:0]    reg_val;
    logic [1:0]    kind;
    logic [39:0]   pw;
    logic [7:0]    key;
    bit            typed;
    dlc_pkg::out_t want;
  } step_row_t;

  typedef struct {
    logic [7:0] lockout;
    logic [7:0] motor;
    logic [2:0] attempts;
    int         items;
    int         bad_pct;
  } phase_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata   = '0;
  logic [1:0]  s_axis_tuser   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_addr_i     = '0;
  logic [7:0]  cfg_wdata_i    = '0;

  // Lock model state and its copy of the configuration registers.
  dlc_pkg::mode_e st_mode   = dlc_pkg::MODE_NEW;
  logic [39:0] st_stored    = '0;
  logic [39:0] st_first     = '0;
  logic [2:0]  st_wrong     = '0;
  logic [7:0]  st_ticks     = '0;
  logic        st_buzz      = 1'b0;
  logic [7:0]  cfg_lockout  = dlc_pkg::LOCKOUT_TICKS_RST;
  logic [7:0]  cfg_motor    = dlc_pkg::MOTOR_TICKS_RST;
  logic [2:0]  cfg_attempts = dlc_pkg::MAX_ATTEMPTS_RST;

  dlc_pkg::out_t pending_resp[$];
  dlc_pkg::out_t want_resp;
  step_row_t   dir_tab[$];
  phase_t      phases[NUM_PHASES];
  int          mismatches  = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_reqs   = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          quiet_cycles = 0;

  password_door_lock_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    // tdata: pass_value [39:0], key_code [47:40]
    .s_axis_tdata (s_axis_tdata),
    // tuser: req_type [1:0]
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    // tdata: result_code, mode, attempts, buzzer_on, motor_lock, motor_unlock, zero fill
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic dlc_pkg::out_t predict_lock_response(input logic [1:0] kind,
                                                          input logic [39:0] pw,
                                                          input logic [7:0] key);
    dlc_pkg::res_e res;
    dlc_pkg::out_t resp;
    res = dlc_pkg::RES_IGNORED;
    case (kind)
      dlc_pkg::REQ_PASS: begin
        case (st_mode)
          dlc_pkg::MODE_NEW: begin
            st_first = pw;
            st_mode  = dlc_pkg::MODE_CONFIRM;
            res      = dlc_pkg::RES_CONFIRM;
          end
          dlc_pkg::MODE_CONFIRM: begin
            if (pw == st_first) begin
              st_stored = pw;
              st_mode   = dlc_pkg::MODE_MENU;
              res       = dlc_pkg::RES_SET_OK;
            end else begin
              st_mode = dlc_pkg::MODE_NEW;
              res     = dlc_pkg::RES_SET_BAD;
            end
          end
          dlc_pkg::MODE_CHK_CHANGE, dlc_pkg::MODE_CHK_OPEN: begin
            if (pw == st_stored) begin
              st_wrong = '0;
              res      = dlc_pkg::RES_PASS_OK;
              if (st_mode == dlc_pkg::MODE_CHK_OPEN) begin
                st_ticks = '0;
                st_mode  = dlc_pkg::MODE_LOCKING;
              end else begin
                st_mode = dlc_pkg::MODE_NEW;
              end
            end else begin
              // The wrong count wraps at three bits before it is compared.
              st_wrong = st_wrong + 3'd1;
              if (st_wrong == cfg_attempts) begin
                st_wrong = '0;
                st_buzz  = 1'b1;
                st_ticks = '0;
                st_mode  = dlc_pkg::MODE_LOCKOUT;
                res      = dlc_pkg::RES_LOCKOUT;
              end else begin
                res = dlc_pkg::RES_WRONG;
              end
            end
          end
          default: ;
        endcase
      end
      dlc_pkg::REQ_KEY: begin
        if (st_mode == dlc_pkg::MODE_MENU &&
            (key == dlc_pkg::KEY_CHANGE || key == dlc_pkg::KEY_OPEN)) begin
          st_wrong = '0;
          st_mode  = (key == dlc_pkg::KEY_CHANGE) ? dlc_pkg::MODE_CHK_CHANGE
                                                  : dlc_pkg::MODE_CHK_OPEN;
          res      = dlc_pkg::RES_NONE;
        end
      end
      dlc_pkg::REQ_TICK: begin
        // Ticks count in every mode; only the timed modes compare the count.
        st_ticks = st_ticks + 8'd1;
        res      = dlc_pkg::RES_NONE;
        case (st_mode)
          dlc_pkg::MODE_LOCKOUT: begin
            if (st_ticks == cfg_lockout) begin
              st_ticks = '0;
              st_buzz  = 1'b0;
              st_mode  = dlc_pkg::MODE_MENU;
              res      = dlc_pkg::RES_LOCKOUT_OVER;
            end
          end
          dlc_pkg::MODE_LOCKING: begin
            if (st_ticks == cfg_motor) begin
              st_ticks = '0;
              st_mode  = dlc_pkg::MODE_UNLOCKING;
              res      = dlc_pkg::RES_UNLOCKING;
            end
          end
          dlc_pkg::MODE_UNLOCKING: begin
            if (st_ticks == cfg_motor) begin
              st_ticks = '0;
              st_mode  = dlc_pkg::MODE_MENU;
              res      = dlc_pkg::RES_DONE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    resp.result_code  = res;
    resp.mode         = st_mode;
    resp.attempts     = st_wrong;
    resp.buzzer_on    = st_buzz;
    resp.motor_lock   = (st_mode == dlc_pkg::MODE_LOCKING);
    resp.motor_unlock = (st_mode == dlc_pkg::MODE_UNLOCKING);
    return resp;
  endfunction

  function automatic step_row_t event_row(input logic [1:0] kind, input logic [39:0] pw,
                                          input logic [7:0] key);
    step_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = dlc_pkg::CFG_LOCKOUT_TICKS;
    r.reg_val = '0;
    r.kind    = kind;
    r.pw      = pw;
    r.key     = key;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic step_row_t checked_row(input logic [1:0] kind, input logic [39:0] pw,
                                            input logic [7:0] key, input dlc_pkg::res_e res,
                                            input dlc_pkg::mode_e md,
                                            input logic [2:0] att, input logic buzz);
    step_row_t r;
    r = event_row(kind, pw, key);
    r.typed                = 1'b1;
    r.want.result_code     = res;
    r.want.mode            = md;
    r.want.attempts        = att;
    r.want.buzzer_on       = buzz;
    r.want.motor_lock      = (md == dlc_pkg::MODE_LOCKING);
    r.want.motor_unlock    = (md == dlc_pkg::MODE_UNLOCKING);
    return r;
  endfunction

  function automatic step_row_t reg_row(input dlc_pkg::cfg_e idx, input logic [7:0] val);
    step_row_t r;
    r = event_row(dlc_pkg::REQ_TICK, '0, '0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void note_field(input string name, input int want_v, input int seen_v);
    if (want_v != seen_v) begin
      $error("%s expected %0d got %0d", name, want_v, seen_v);
      mismatches++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_event(input logic [1:0] kind, input logic [39:0] pw,
                            input logic [7:0] key, input bit typed,
                            input dlc_pkg::out_t want);
    dlc_pkg::out_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {key, pw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = predict_lock_response(kind, pw, key);
    pending_resp.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  // Mostly well-formed input for the current mode, the rest is noise.
  task automatic send_random_event(input int bad_pct);
    logic [1:0]  kind;
    logic [39:0] pw;
    logic [39:0] flip;
    logic [7:0]  key;
    int          pick;
    kind = 2'($urandom);
    pw   = {8'($urandom), 32'($urandom)};
    key  = 8'($urandom);
    flip = 40'd1 << $urandom_range(39);
    pick = $urandom_range(99);
    if ($urandom_range(99) >= 12) begin
      case (st_mode)
        dlc_pkg::MODE_NEW: begin
          kind = dlc_pkg::REQ_PASS;
          if (pick < 40) pw = st_stored ^ flip;
        end
        dlc_pkg::MODE_CONFIRM: begin
          kind = dlc_pkg::REQ_PASS;
          if (pick >= bad_pct / 2) pw = st_first;
          else if (pick % 2 == 0) pw = st_first ^ flip;
        end
        dlc_pkg::MODE_MENU: begin
          kind = dlc_pkg::REQ_KEY;
          if (pick < 45) key = dlc_pkg::KEY_OPEN;
          else if (pick < 90) key = dlc_pkg::KEY_CHANGE;
          else if (pick < 95) kind = dlc_pkg::REQ_TICK;
        end
        dlc_pkg::MODE_CHK_CHANGE, dlc_pkg::MODE_CHK_OPEN: begin
          kind = dlc_pkg::REQ_PASS;
          if (pick >= bad_pct) pw = st_stored;
          else if (pick % 2 == 0) pw = st_stored ^ flip;
        end
        default: kind = dlc_pkg::REQ_TICK;
      endcase
    end
    send_event(kind, pw, key, 1'b0, '0);
  endtask

  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input dlc_pkg::cfg_e idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dlc_pkg::CFG_LOCKOUT_TICKS: cfg_lockout  = val;
      dlc_pkg::CFG_MOTOR_TICKS:   cfg_motor    = val;
      dlc_pkg::CFG_MAX_ATTEMPTS:  cfg_attempts = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_reqs != hold_seen) begin
      hold_seen++;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_resp.size() == 0) begin
        $error("result transaction with nothing outstanding: result_code %0d",
               m_axis_tdata[3:0]);
        mismatches++;
      end else begin
        want_resp = pending_resp.pop_front();
        note_field("result_code", want_resp.result_code, m_axis_tdata[3:0]);
        note_field("mode", want_resp.mode, m_axis_tdata[6:4]);
        note_field("attempts", want_resp.attempts, m_axis_tdata[9:7]);
        note_field("buzzer_on", want_resp.buzzer_on, m_axis_tdata[10]);
        note_field("motor_lock", want_resp.motor_lock, m_axis_tdata[11]);
        note_field("motor_unlock", want_resp.motor_unlock, m_axis_tdata[12]);
        note_field("zero_fill", 0, m_axis_tdata[15:13]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed part: reset behavior, field extremes, every code and the out-of-place events.
    dir_tab.push_back(checked_row(dlc_pkg::REQ_KEY, '0, dlc_pkg::KEY_CHANGE,
                                  dlc_pkg::RES_IGNORED, dlc_pkg::MODE_NEW, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_TICK, '0, '0,
                                  dlc_pkg::RES_NONE, dlc_pkg::MODE_NEW, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(REQ_UNDEFINED, '1, '1,
                                  dlc_pkg::RES_IGNORED, dlc_pkg::MODE_NEW, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '1, '0,
                                  dlc_pkg::RES_CONFIRM, dlc_pkg::MODE_CONFIRM, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '0, '0,
                                  dlc_pkg::RES_SET_BAD, dlc_pkg::MODE_NEW, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '0, '0,
                                  dlc_pkg::RES_CONFIRM, dlc_pkg::MODE_CONFIRM, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '0, '1,
                                  dlc_pkg::RES_SET_OK, dlc_pkg::MODE_MENU, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, 40'h12_3456_789A, '0,
                                  dlc_pkg::RES_IGNORED, dlc_pkg::MODE_MENU, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_KEY, '0, 8'hFF,
                                  dlc_pkg::RES_IGNORED, dlc_pkg::MODE_MENU, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_KEY, '0, dlc_pkg::KEY_CHANGE,
                                  dlc_pkg::RES_NONE, dlc_pkg::MODE_CHK_CHANGE, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, 40'h1, '0,
                                  dlc_pkg::RES_WRONG, dlc_pkg::MODE_CHK_CHANGE, 3'd1, 1'b0));
    // Only the top byte differs, after four zero bytes.
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, 40'h80_0000_0000, '0,
                                  dlc_pkg::RES_WRONG, dlc_pkg::MODE_CHK_CHANGE, 3'd2, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '1, '0,
                                  dlc_pkg::RES_LOCKOUT, dlc_pkg::MODE_LOCKOUT, 3'd0, 1'b1));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_KEY, '0, dlc_pkg::KEY_OPEN,
                                  dlc_pkg::RES_IGNORED, dlc_pkg::MODE_LOCKOUT, 3'd0, 1'b1));
    dir_tab.push_back(reg_row(dlc_pkg::CFG_LOCKOUT_TICKS, 8'd1));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_TICK, '0, '0,
                                  dlc_pkg::RES_LOCKOUT_OVER, dlc_pkg::MODE_MENU, 3'd0, 1'b0));
    dir_tab.push_back(reg_row(dlc_pkg::CFG_MOTOR_TICKS, 8'd1));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_KEY, '0, dlc_pkg::KEY_OPEN,
                                  dlc_pkg::RES_NONE, dlc_pkg::MODE_CHK_OPEN, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '0, '0,
                                  dlc_pkg::RES_PASS_OK, dlc_pkg::MODE_LOCKING, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '0, '0,
                                  dlc_pkg::RES_IGNORED, dlc_pkg::MODE_LOCKING, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_TICK, '0, '0,
                                  dlc_pkg::RES_UNLOCKING, dlc_pkg::MODE_UNLOCKING, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_TICK, '0, '0,
                                  dlc_pkg::RES_DONE, dlc_pkg::MODE_MENU, 3'd0, 1'b0));
    dir_tab.push_back(reg_row(dlc_pkg::CFG_MAX_ATTEMPTS, 8'd1));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_KEY, '0, dlc_pkg::KEY_CHANGE,
                                  dlc_pkg::RES_NONE, dlc_pkg::MODE_CHK_CHANGE, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, 40'h100, '0,
                                  dlc_pkg::RES_LOCKOUT, dlc_pkg::MODE_LOCKOUT, 3'd0, 1'b1));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_TICK, '0, '0,
                                  dlc_pkg::RES_LOCKOUT_OVER, dlc_pkg::MODE_MENU, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_KEY, '0, dlc_pkg::KEY_CHANGE,
                                  dlc_pkg::RES_NONE, dlc_pkg::MODE_CHK_CHANGE, 3'd0, 1'b0));
    dir_tab.push_back(checked_row(dlc_pkg::REQ_PASS, '0, '0,
                                  dlc_pkg::RES_PASS_OK, dlc_pkg::MODE_NEW, 3'd0, 1'b0));
    dir_tab.push_back(event_row(dlc_pkg::REQ_PASS, 40'hA5_5A00_C33C, '0));
    dir_tab.push_back(event_row(dlc_pkg::REQ_PASS, 40'hA5_5A00_C33C, '0));

    phases[0] = '{8'd3,   8'd2,   3'd1, 250, 40};
    phases[1] = '{8'd255, 8'd255, 3'd7, 600, 50};
    phases[2] = '{8'd1,   8'd1,   3'd2, 250, 30};
    phases[3] = '{8'd17,  8'd5,   3'd7, 250, 60};
    phases[4] = '{8'd240, 8'd60,  3'd3, 300, 30};
    phases[5] = '{8'd2,   8'd9,   3'd4, 225, 40};

    tx_idle_pct = 38;
    rx_idle_pct = 60;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_responses();
        write_cfg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_event(dir_tab[i].kind, dir_tab[i].pw, dir_tab[i].key, dir_tab[i].typed,
                   dir_tab[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin
          tx_idle_pct = 38;
          rx_idle_pct = 60;
        end
        1: begin
          tx_idle_pct = 60;
          rx_idle_pct = 38;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // Registers change only with nothing in flight.
      drain_responses();
      write_cfg(dlc_pkg::CFG_LOCKOUT_TICKS, phases[p].lockout);
      write_cfg(dlc_pkg::CFG_MOTOR_TICKS, phases[p].motor);
      write_cfg(dlc_pkg::CFG_MAX_ATTEMPTS, {5'd0, phases[p].attempts});
      for (int n = 0; n < phases[p].items; n++) begin
        // Long receiver hold-off while events keep coming, so the input side backs up.
        if (n == 100 && (p == 0 || p == 3)) hold_reqs++;
        send_random_event(phases[p].bad_pct);
      end
    end

    drain_responses();
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/dlc_pkg.sv
sv/dlc_core.sv
sv/password_door_lock_controller.sv
test/tb.sv
